### src/ahw_pkg.sv
// Package for the angle to hue-wheel color unit: register indexes and fixed-point constants.
`timescale 1ns / 1ps
package ahw_pkg;

  typedef enum logic [1:0] {
    REG_DEGREES = 2'd0,
    REG_HALF    = 2'd1,
    REG_SAT     = 2'd2,
    REG_VALUE   = 2'd3
  } cfg_reg_t;

  localparam int unsigned AngleW  = 16;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned SectorW = 4;

  // round(179 * 2^16 / (2*pi))
  localparam logic [20:0] RadHueMul   = 21'd1867038;
  localparam logic [7:0]  HueSpan     = 8'd179;
  localparam logic [7:0]  HueMax      = 8'hFF;
  // y / 45 as (y * 11651) >> 19, exact for y below 11520
  localparam logic [13:0] DegRecip    = 14'd11651;
  localparam logic [14:0] DegSatLimit = 15'd11520;
  // floor(r * 2^16 / 179) as (r * FracRecip) >> 16
  localparam logic [24:0] FracRecip   = 25'd23994231;
  // floor(n / 255) as (n * Div255Recip) >> 32, n below 2^24
  localparam logic [24:0] Div255Recip = 25'd16843010;
  localparam logic [16:0] OneQ16      = 17'h10000;

  localparam logic [3:0] Sector1 = 4'd1;
  localparam logic [3:0] Sector2 = 4'd2;
  localparam logic [3:0] Sector3 = 4'd3;
  localparam logic [3:0] Sector4 = 4'd4;
  localparam logic [3:0] Sector5 = 4'd5;

  localparam int unsigned Latency = 9;

endpackage

### src/angle_to_hue_wheel_color_unit.sv
// Angle to hue-wheel color unit: nine-stage pipeline from angle to hue to BGR.
// Each start transfer shifts a valid bit down the chain of stage valids; done is the last of them.
// Throughput: one angle per clock while busy is low; busy is low except during reset.
// Stages hold multipliers, add-and-compare logic or selection muxes.
// Reset (rst, synchronous) clears all stage valids and loads the register defaults.
// Results cannot be stalled: done is high for exactly one cycle per transfer.
`timescale 1ns / 1ps
module angle_to_hue_wheel_color_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [ahw_pkg::AngleW-1:0]       angle,
  output logic                             done,
  output logic [ahw_pkg::ChanW-1:0]        blue,
  output logic [ahw_pkg::ChanW-1:0]        green,
  output logic [ahw_pkg::ChanW-1:0]        red,
  output logic [ahw_pkg::ChanW-1:0]        hue,
  input  logic                             cfg_write,
  input  logic [1:0]                       cfg_index,
  input  logic [ahw_pkg::ChanW-1:0]        cfg_data
);

  // configuration
  logic       deg_mode;
  logic       half;
  logic [7:0] sat;
  logic [7:0] val;

  always_ff @(posedge clk) begin
    if (rst) begin
      deg_mode <= 1'b0;
      half     <= 1'b1;
      sat      <= 8'hFF;
      val      <= 8'hFF;
    end else if (cfg_write) begin
      case (ahw_pkg::cfg_reg_t'(cfg_index))
        ahw_pkg::REG_DEGREES: deg_mode <= cfg_data[0];
        ahw_pkg::REG_HALF:    half     <= cfg_data[0];
        ahw_pkg::REG_SAT:     sat      <= cfg_data;
        ahw_pkg::REG_VALUE:   val      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  logic [ahw_pkg::Latency-1:0] valid;
  logic                        take;
  assign take = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[ahw_pkg::Latency-2:0], take};
    end
  end
  assign done = valid[ahw_pkg::Latency-1];

  // stage 1: angle products
  logic [36:0] rad_prod;
  logic [23:0] deg_prod;

  always_ff @(posedge clk) begin
    rad_prod <= 37'(angle) * 37'(ahw_pkg::RadHueMul);
    deg_prod <= 24'(angle) * 24'(ahw_pkg::HueSpan);
  end

  // stage 2: radian hue, degree reciprocal product
  logic [8:0]  rad_shift;
  logic [14:0] deg_y;
  logic [7:0]  rad_hue;
  logic        deg_big;
  logic [27:0] deg_mul;

  always_comb begin
    rad_shift = half ? rad_prod[36:28] : {1'b0, rad_prod[36:29]};
    deg_y     = half ? deg_prod[23:9] : {1'b0, deg_prod[23:10]};
  end

  always_ff @(posedge clk) begin
    rad_hue <= rad_shift[8] ? ahw_pkg::HueMax : rad_shift[7:0];
    deg_big <= (deg_y >= ahw_pkg::DegSatLimit);
    deg_mul <= 28'(deg_y[13:0]) * 28'(ahw_pkg::DegRecip);
  end

  // stage 3: hue
  logic [7:0] hue3;

  always_ff @(posedge clk) begin
    if (!deg_mode) begin
      hue3 <= rad_hue;
    end else if (deg_big) begin
      hue3 <= ahw_pkg::HueMax;
    end else begin
      hue3 <= deg_mul[26:19];
    end
  end

  // stage 4: sector and remainder
  logic [10:0] h6;
  logic [3:0]  sector_next;
  logic [7:0]  rem_next;
  logic [3:0]  sector4;
  logic [7:0]  rem4;
  logic [7:0]  hue4;

  always_comb begin
    h6          = 11'({hue3, 2'b00}) + 11'({hue3, 1'b0});
    sector_next = '0;
    rem_next    = h6[7:0];
    for (int i = 1; i <= 8; i++) begin
      if (h6 >= 11'(i) * 11'(ahw_pkg::HueSpan)) begin
        sector_next = 4'(i);
        rem_next    = 8'(h6 - 11'(i) * 11'(ahw_pkg::HueSpan));
      end
    end
  end

  always_ff @(posedge clk) begin
    sector4 <= sector_next;
    rem4    <= rem_next;
    hue4    <= hue3;
  end

  // stage 5: fraction product
  logic [32:0] frac_prod;
  logic [3:0]  sector5;
  logic [7:0]  hue5;

  always_ff @(posedge clk) begin
    frac_prod <= 33'(rem4) * 33'(ahw_pkg::FracRecip);
    sector5   <= sector4;
    hue5      <= hue4;
  end

  // stage 6: saturation times fraction
  logic [15:0] frac;
  logic [16:0] frac_inv;
  logic [23:0] nq;
  logic [23:0] nt;
  logic [3:0]  sector6;
  logic [7:0]  hue6;

  always_comb begin
    frac     = frac_prod[31:16];
    frac_inv = ahw_pkg::OneQ16 - 17'(frac);
  end

  always_ff @(posedge clk) begin
    nq      <= 24'(sat) * 24'(frac);
    nt      <= 24'(sat) * 24'(frac_inv);
    sector6 <= sector5;
    hue6    <= hue5;
  end

  // stage 7: divide by 255
  logic [48:0] q_prod;
  logic [48:0] t_prod;
  logic [16:0] q_quot;
  logic [16:0] t_quot;
  logic [3:0]  sector7;
  logic [7:0]  hue7;

  always_comb begin
    q_prod = 49'(nq) * 49'(ahw_pkg::Div255Recip);
    t_prod = 49'(nt) * 49'(ahw_pkg::Div255Recip);
  end

  always_ff @(posedge clk) begin
    q_quot  <= q_prod[48:32];
    t_quot  <= t_prod[48:32];
    sector7 <= sector6;
    hue7    <= hue6;
  end

  // stage 8: factors per sector
  logic [16:0] p_sub;
  logic [16:0] fp;
  logic [16:0] fq;
  logic [16:0] ft;
  logic [16:0] fr_next;
  logic [16:0] fg_next;
  logic [16:0] fb_next;
  logic [16:0] fr;
  logic [16:0] fg;
  logic [16:0] fb;
  logic [7:0]  hue8;

  always_comb begin
    // sat * 65536 / 255 = sat * 257 + sat / 255
    p_sub   = 17'({sat, 8'h00}) + 17'(sat) + 17'(sat == 8'hFF);
    fp      = ahw_pkg::OneQ16 - p_sub;
    fq      = ahw_pkg::OneQ16 - q_quot;
    ft      = ahw_pkg::OneQ16 - t_quot;
    fr_next = ahw_pkg::OneQ16;
    fg_next = ahw_pkg::OneQ16;
    fb_next = ahw_pkg::OneQ16;
    case (sector7)
      ahw_pkg::Sector1: begin
        fr_next = fq;
        fb_next = fp;
      end
      ahw_pkg::Sector2: begin
        fr_next = fp;
        fb_next = ft;
      end
      ahw_pkg::Sector3: begin
        fr_next = fp;
        fg_next = fq;
      end
      ahw_pkg::Sector4: begin
        fr_next = ft;
        fg_next = fp;
      end
      ahw_pkg::Sector5: begin
        fg_next = fp;
        fb_next = fq;
      end
      default: begin
        fg_next = ft;
        fb_next = fp;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    fr   <= fr_next;
    fg   <= fg_next;
    fb   <= fb_next;
    hue8 <= hue7;
  end

  // stage 9: scale by value
  logic [24:0] r_prod;
  logic [24:0] g_prod;
  logic [24:0] b_prod;

  always_comb begin
    r_prod = 25'(val) * 25'(fr);
    g_prod = 25'(val) * 25'(fg);
    b_prod = 25'(val) * 25'(fb);
  end

  always_ff @(posedge clk) begin
    red   <= r_prod[23:16];
    green <= g_prod[23:16];
    blue  <= b_prod[23:16];
    hue   <= hue8;
  end

endmodule

### src/ahw_checker.sv
// Port-level checker for the angle to hue-wheel color unit, bound to the top level.
`timescale 1ns / 1ps
module ahw_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 9))
    else $error("done without a start transfer nine cycles earlier");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    ($past(start && !busy, 9) && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) &&
     !$past(rst, 4) && !$past(rst, 5) && !$past(rst, 6) && !$past(rst, 7) &&
     !$past(rst, 8)) |-> done)
    else $error("start transfer produced no done");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("done right after reset");

  a_ready_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !busy)
    else $error("busy after reset release");

endmodule

bind angle_to_hue_wheel_color_unit ahw_checker u_ahw_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
